// ===== src/mpbm_pkg.sv =====
package mpbm_pkg;

  // field widths fixed by the item format
  localparam int ACT_W      = 3;
  localparam int STATE_ID_W = 10;
  localparam int SYM_W      = 8;
  localparam int POS_W      = 32;
  localparam int CNT_W      = 32;

  // default automaton size
  localparam int DEF_NUM_STATES    = 1024;
  localparam int DEF_ALPHABET_SIZE = 256;

  // action codes
  typedef enum logic [ACT_W-1:0] {
    ACT_START   = 3'd0,
    ACT_GOTO_WR = 3'd1,
    ACT_FAIL_WR = 3'd2,
    ACT_MARK_WR = 3'd3,
    ACT_SCAN    = 3'd4
  } action_t;

  // controller to datapath commands
  typedef struct packed {
    logic clear_en;
    logic start_scan;
    logic write_goto;
    logic write_fail;
    logic write_mark;
    logic load_scan;
    logic follow_fail;
    logic take_target;
    logic set_root;
    logic emit;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic hit;
    logic at_root;
    logic steps_done;
    logic marked;
    logic out_free;
  } status_t;

endpackage

// ===== src/mpbm_ctrl.sv =====
module mpbm_ctrl
  import mpbm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ACT_W-1:0] action,
  input  status_t          st,
  output cmd_t             cmd
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_MARK
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (st.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (action_t'(action))
            ACT_START:   cmd.start_scan = 1'b1;
            ACT_GOTO_WR: cmd.write_goto = 1'b1;
            ACT_FAIL_WR: cmd.write_fail = 1'b1;
            ACT_MARK_WR: cmd.write_mark = 1'b1;
            ACT_SCAN: begin
              cmd.load_scan = 1'b1;
              state_next    = S_LOOKUP;
            end
            default: ;
          endcase
        end
      end
      S_LOOKUP: begin
        // goto hit wins, then root or exhausted walk, else one failure step
        priority if (st.hit) begin
          cmd.take_target = 1'b1;
          state_next      = S_MARK;
        end else if (st.at_root || st.steps_done) begin
          cmd.set_root = 1'b1;
          state_next   = S_MARK;
        end else begin
          cmd.follow_fail = 1'b1;
        end
      end
      S_MARK: begin
        if (!st.marked) begin
          state_next = S_IDLE;
        end else if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/mpbm_datapath.sv =====
module mpbm_datapath
  import mpbm_pkg::*;
#(
  parameter int NUM_STATES    = DEF_NUM_STATES,
  parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output status_t               st,
  input  logic [STATE_ID_W-1:0] state_id,
  input  logic [SYM_W-1:0]      symbol,
  input  logic [STATE_ID_W-1:0] target_state,
  input  logic                  entry_valid,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [POS_W-1:0]      match_position,
  output logic [STATE_ID_W-1:0] match_state,
  output logic [CNT_W-1:0]      match_count
);

  localparam int SW     = $clog2(NUM_STATES);
  localparam int AW     = $clog2(ALPHABET_SIZE);
  localparam int GA     = SW + AW;
  localparam int STEP_W = $clog2(NUM_STATES + 1);

  // tables
  logic [SW:0]   goto_mem [1 << GA];
  logic [SW-1:0] fail_mem [1 << SW];
  logic          mark_mem [1 << SW];

  // registers
  logic [GA-1:0]     clr_addr;
  logic [SW:0]       goto_q;
  logic [SW-1:0]     fail_q;
  logic              mark_q;
  logic [SW-1:0]     cur_state;
  logic [SW-1:0]     walk_state;
  logic [SYM_W-1:0]  scan_sym;
  logic              scan_sym_ok;
  logic [STEP_W-1:0] steps;
  logic [POS_W-1:0]  scan_pos;
  logic [POS_W-1:0]  byte_position;
  logic [CNT_W-1:0]  matches_seen;

  logic          sid_ok, sym_ok, tgt_ok;
  logic          goto_we, goto_re, mark_re;
  logic [GA-1:0] goto_waddr, goto_raddr;
  logic [SW:0]   goto_wdata;
  logic [SW-1:0] rd_state, mark_raddr;
  logic [CNT_W-1:0] matches_next;

  // range checks on written entries
  assign sid_ok = (32'(state_id) < 32'(NUM_STATES));
  assign tgt_ok = (32'(target_state) < 32'(NUM_STATES));
  assign sym_ok = (32'(symbol) < 32'(ALPHABET_SIZE));

  // goto port: clear sweep, table writes, walk reads
  assign goto_we    = cmd.clear_en || (cmd.write_goto && sid_ok && sym_ok && tgt_ok);
  assign goto_waddr = cmd.clear_en ? clr_addr : {SW'(state_id), AW'(symbol)};
  assign goto_wdata = (cmd.clear_en || !entry_valid) ? '0 : {1'b1, SW'(target_state)};
  assign goto_re    = cmd.load_scan || cmd.follow_fail;
  assign rd_state   = cmd.load_scan ? cur_state : fail_q;
  assign goto_raddr = cmd.load_scan ? {rd_state, AW'(symbol)} : {rd_state, AW'(scan_sym)};

  always_ff @(posedge clk) begin
    if (goto_we) begin
      goto_mem[goto_waddr] <= goto_wdata;
    end else if (goto_re) begin
      goto_q <= goto_mem[goto_raddr];
    end
  end

  // failure links, read alongside the goto entry of the same state
  always_ff @(posedge clk) begin
    if (cmd.write_fail && sid_ok && tgt_ok) begin
      fail_mem[SW'(state_id)] <= SW'(target_state);
    end else if (goto_re) begin
      fail_q <= fail_mem[rd_state];
    end
  end

  // output marks, cleared by the same sweep one state row at a time
  assign mark_re    = cmd.take_target || cmd.set_root;
  assign mark_raddr = cmd.take_target ? goto_q[SW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (cmd.clear_en) begin
      mark_mem[clr_addr[GA-1:AW]] <= 1'b0;
    end else if (cmd.write_mark && sid_ok) begin
      mark_mem[SW'(state_id)] <= entry_valid;
    end else if (mark_re) begin
      mark_q <= mark_mem[mark_raddr];
    end
  end

  // clear sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_en) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // walk registers for the byte in flight
  always_ff @(posedge clk) begin
    if (cmd.load_scan) begin
      walk_state  <= cur_state;
      scan_sym    <= symbol;
      scan_sym_ok <= sym_ok;
      steps       <= '0;
      scan_pos    <= byte_position;
    end else if (cmd.follow_fail) begin
      walk_state <= fail_q;
      steps      <= steps + 1'b1;
    end
  end

  assign matches_next = (matches_seen == '1) ? matches_seen : matches_seen + 1'b1;

  // scan context with saturating counters
  always_ff @(posedge clk) begin
    if (rst || cmd.start_scan) begin
      cur_state     <= '0;
      byte_position <= '0;
      matches_seen  <= '0;
    end else begin
      if (cmd.load_scan && byte_position != '1) begin
        byte_position <= byte_position + 1'b1;
      end
      if (cmd.take_target) begin
        cur_state <= goto_q[SW-1:0];
      end else if (cmd.set_root) begin
        cur_state <= '0;
      end
      if (cmd.emit) begin
        matches_seen <= matches_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      match_position <= scan_pos;
      match_state    <= STATE_ID_W'(cur_state);
      match_count    <= matches_next;
    end
  end

  // status back to the controller
  assign st.clr_last   = (clr_addr == '1);
  assign st.hit        = goto_q[SW] && scan_sym_ok;
  assign st.at_root    = (walk_state == '0);
  assign st.steps_done = (steps == STEP_W'(NUM_STATES));
  assign st.marked     = mark_q;
  assign st.out_free   = !out_valid || out_ready;

endmodule

// ===== src/multi_pattern_byte_matcher_top.sv =====
// result path: a marked scan byte reaches the result register after its goto
//   read, F failure-link steps of one goto/failure read each, and a mark read
// intake: start and table writes are taken without leaving idle; after a scan
//   byte the next item waits for the walk, the mark read and any waiting result
// reset: sweeps goto memory and output marks, all 2^(clog2(NUM_STATES) +
//   clog2(ALPHABET_SIZE)) goto entries (262144 at defaults), in_ready low
module multi_pattern_byte_matcher_top
  import mpbm_pkg::*;
#(
  parameter int NUM_STATES    = DEF_NUM_STATES,
  parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ACT_W-1:0]      action,
  input  logic [STATE_ID_W-1:0] state_id,
  input  logic [SYM_W-1:0]      symbol,
  input  logic [STATE_ID_W-1:0] target_state,
  input  logic                  entry_valid,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [POS_W-1:0]      match_position,
  output logic [STATE_ID_W-1:0] match_state,
  output logic [CNT_W-1:0]      match_count
);

  cmd_t    cmd;
  status_t st;

  // sequencer
  mpbm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .st       (st),
    .cmd      (cmd)
  );

  // tables, walk registers and result register
  mpbm_datapath #(
    .NUM_STATES    (NUM_STATES),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .state_id       (state_id),
    .symbol         (symbol),
    .target_state   (target_state),
    .entry_valid    (entry_valid),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .match_position (match_position),
    .match_state    (match_state),
    .match_count    (match_count)
  );

endmodule

// ===== src/mpbm_checker.sv =====
module mpbm_checker
  import mpbm_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [POS_W-1:0]      match_position,
  input logic [STATE_ID_W-1:0] match_state,
  input logic [CNT_W-1:0]      match_count
);

  // clearing sweep follows reset, so no item is taken right after it
  a_no_accept_after_rst: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("in_ready high right after reset");

  // result register is empty after reset
  a_no_result_after_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high right after reset");

  // every result counts itself
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (match_count != '0))
    else $error("result with zero match count");

  // a stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(match_position)
      && $stable(match_state) && $stable(match_count))
    else $error("stalled result changed");

endmodule

bind multi_pattern_byte_matcher_top mpbm_checker u_mpbm_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .match_position (match_position),
  .match_state    (match_state),
  .match_count    (match_count)
);
